// File: sv/lneb_pkg.sv
// lneb_pkg: shared constants, codes and types for the long-name entry builder
// no dependencies; imported by both rtl modules, lfn_entry_checker and tb_top
`timescale 1ns / 1ps
`default_nettype none

package lneb_pkg;

   // name limits and entry geometry
   localparam int NAME_MAX        = 255;
   localparam int CHARS_PER_ENTRY = 13;
   localparam int SHORT_LEN       = 11;
   localparam int ENTRY_BYTES     = 32;

   // counter and address widths
   localparam int LEN_W  = 9;   // holds 0 .. 511, past NAME_MAX
   localparam int ADDR_W = 8;   // index into the name store
   localparam int SLOT_W = 4;   // character slot within one entry
   localparam int ORD_W  = 5;   // entry count, at most 20
   localparam int SCNT_W = 4;   // short-name byte count

   // fixed entry bytes and character codes
   localparam logic [7:0]  ATTR_LONG_NAME  = 8'h0F;
   localparam logic [7:0]  ORDER_LAST_FLAG = 8'h40;
   localparam logic [15:0] CHAR_TERM       = 16'h0000;
   localparam logic [15:0] CHAR_PAD        = 16'hFFFF;

   // byte offset of each character slot within an entry
   localparam logic [4:0] SLOT_OFFSET [CHARS_PER_ENTRY] = '{
      5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd14, 5'd16, 5'd18, 5'd20, 5'd22, 5'd24, 5'd28, 5'd30
   };

   // request function codes
   typedef enum logic [1:0] {
      FUNC_SHORT = 2'd0,
      FUNC_NAME  = 2'd1,
      FUNC_END   = 2'd2
   } func_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_LOAD,
      ST_FETCH,
      ST_LASTCAP,
      ST_EMIT
   } state_type;

   // what a character slot holds
   typedef enum logic [1:0] {
      CLS_STORED,
      CLS_TERM,
      CLS_PAD
   } char_cls_type;

   // thirteen UTF-16 characters of one entry
   typedef logic [CHARS_PER_ENTRY-1:0][15:0] char_row_type;

   // per-entry header fields handed to the packer
   typedef struct packed {
      logic [7:0] order;
      logic [7:0] checksum;
      logic       err;
   } entry_hdr_type;

endpackage

`default_nettype wire

// File: sv/lneb_pack.sv
// lneb_pack: lays out one 32-byte long-name entry as four little-endian words
// depends on lneb_pkg for the slot offsets, fixed bytes and header struct
`timescale 1ns / 1ps
`default_nettype none

module lneb_pack (
   input  var lneb_pkg::entry_hdr_type hdr,
   input  var lneb_pkg::char_row_type  chars,
   output logic [63:0]                 word0,
   output logic [63:0]                 word1,
   output logic [63:0]                 word2,
   output logic [63:0]                 word3
);
   import lneb_pkg::*;

   logic [ENTRY_BYTES-1:0][7:0] entry_bytes;

   // place header bytes and the characters at their slot offsets; all bytes stay zero on error
   always_comb begin
      entry_bytes = '0;
      if (!hdr.err) begin
         entry_bytes[0]  = hdr.order;
         entry_bytes[11] = ATTR_LONG_NAME;
         entry_bytes[13] = hdr.checksum;
         for (int s = 0; s < CHARS_PER_ENTRY; s++) begin
            entry_bytes[SLOT_OFFSET[s]]        = chars[s][7:0];
            entry_bytes[SLOT_OFFSET[s] + 5'd1] = chars[s][15:8];
         end
      end
   end

   // byte 0 lands in the low bits of each word
   assign word0 = entry_bytes[7:0];
   assign word1 = entry_bytes[15:8];
   assign word2 = entry_bytes[23:16];
   assign word3 = entry_bytes[31:24];

endmodule

`default_nettype wire

// File: sv/long_name_entry_builder.sv
// long_name_entry_builder: short-name and name requests are taken one per cycle while
// req_stall is low; for each entry an end request reads the name store once per slot,
// captures the read data and loads the packed entry into the result register; an end on
// an empty name gives no entry, and a too-long end gives a single error result; requests
// stall from any other end request until its last entry is loaded; reset is synchronous
// and clears the control state but not the name store; depends on lneb_pkg and lneb_pack
`timescale 1ns / 1ps
`default_nettype none

module long_name_entry_builder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_entry_word0,
   output logic [63:0] rsp_entry_word1,
   output logic [63:0] rsp_entry_word2,
   output logic [63:0] rsp_entry_word3,
   output logic        rsp_last_entry,
   output logic        rsp_status
);
   import lneb_pkg::*;

   // name store, one synchronous read port
   logic [7:0]        name_mem [NAME_MAX];
   logic [7:0]        rd_data_ff;

   // sequencer
   state_type         state_ff, state_in;
   logic              req_accept;
   logic              rd_en;
   logic              out_free;
   logic              emit_load;
   logic              run_done;

   // name collection state
   logic [LEN_W-1:0]  name_length_ff;
   logic              too_long_ff;
   logic [7:0]        short_checksum_ff;
   logic [SCNT_W-1:0] short_count_ff;
   logic [ORD_W-1:0]  entry_cnt_ff;
   logic [SLOT_W-1:0] slot_mod_ff;
   logic [LEN_W-1:0]  base_ff;

   // entry build state
   logic [LEN_W-1:0]  addr_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [ORD_W-1:0]  order_ff;
   logic              first_ff;
   logic              err_ff;
   char_cls_type      cls_in;
   logic              cap_valid_ff;
   logic [SLOT_W-1:0] cap_slot_ff;
   char_cls_type      cap_cls_ff;
   char_row_type      char_ff;
   logic [15:0]       char_in;

   // packer hookup
   entry_hdr_type     hdr;
   logic [63:0]       word0, word1, word2, word3;

   // result register
   logic              rsp_valid_ff;
   logic [63:0]       word0_ff, word1_ff, word2_ff, word3_ff;
   logic              last_ff;
   logic              status_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_valid && (req_func == FUNC_END)) begin
               if (too_long_ff) begin
                  state_in = ST_EMIT;
               end else if (name_length_ff != '0) begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            if (slot_ff == SLOT_W'(CHARS_PER_ENTRY - 1)) begin
               state_in = ST_LASTCAP;
            end
         end
         ST_LASTCAP: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = run_done ? ST_LOAD : ST_FETCH;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall = 1'b1;
      rd_en     = 1'b0;
      emit_load = 1'b0;
      case (state_ff)
         ST_LOAD:    req_stall = 1'b0;
         ST_FETCH:   rd_en     = 1'b1;
         ST_LASTCAP: rd_en     = 1'b0;
         ST_EMIT:    emit_load = out_free;
         default:    req_stall = 1'b1;
      endcase
   end

   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign run_done   = err_ff || (order_ff == ORD_W'(1));

   // classify the slot being read: stored character, terminator or padding
   always_comb begin
      if (addr_ff < name_length_ff) begin
         cls_in = CLS_STORED;
      end else if (addr_ff == name_length_ff) begin
         cls_in = CLS_TERM;
      end else begin
         cls_in = CLS_PAD;
      end
   end

   // name store write during load, read during fetch; the two never overlap
   always_ff @(posedge clock) begin
      if (req_accept && (req_func == FUNC_NAME) && (name_length_ff < LEN_W'(NAME_MAX))) begin
         name_mem[name_length_ff[ADDR_W-1:0]] <= req_data_byte;
      end
      if (rd_en) begin
         rd_data_ff <= name_mem[addr_ff[ADDR_W-1:0]];
      end
   end

   // control and collection registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_LOAD;
         name_length_ff    <= '0;
         too_long_ff       <= 1'b0;
         short_checksum_ff <= '0;
         short_count_ff    <= '0;
         entry_cnt_ff      <= '0;
         slot_mod_ff       <= '0;
         err_ff            <= 1'b0;
         cap_valid_ff      <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_valid_ff <= rd_en;

         // incoming requests
         if (req_accept) begin
            case (req_func)
               FUNC_SHORT: begin
                  if (short_count_ff < SCNT_W'(SHORT_LEN)) begin
                     short_checksum_ff <= {short_checksum_ff[0], short_checksum_ff[7:1]}
                                          + req_data_byte;
                     short_count_ff    <= short_count_ff + SCNT_W'(1);
                  end
               end
               FUNC_NAME: begin
                  if (name_length_ff < LEN_W'(NAME_MAX)) begin
                     name_length_ff <= name_length_ff + LEN_W'(1);
                     if (slot_mod_ff == '0) begin
                        entry_cnt_ff <= entry_cnt_ff + ORD_W'(1);
                        base_ff      <= name_length_ff;
                     end
                     if (slot_mod_ff == SLOT_W'(CHARS_PER_ENTRY - 1)) begin
                        slot_mod_ff <= '0;
                     end else begin
                        slot_mod_ff <= slot_mod_ff + SLOT_W'(1);
                     end
                  end else begin
                     too_long_ff <= 1'b1;
                  end
               end
               FUNC_END: begin
                  if (too_long_ff) begin
                     err_ff <= 1'b1;
                  end else if (name_length_ff != '0) begin
                     addr_ff  <= base_ff;
                     slot_ff  <= '0;
                     order_ff <= entry_cnt_ff;
                     first_ff <= 1'b1;
                  end else begin
                     short_checksum_ff <= '0;
                     short_count_ff    <= '0;
                  end
               end
               default: begin
               end
            endcase
         end

         // walk the slots of the current entry
         if (rd_en) begin
            addr_ff <= addr_ff + LEN_W'(1);
            slot_ff <= slot_ff + SLOT_W'(1);
         end

         // hand an entry to the result register and step to the next one
         if (emit_load) begin
            rsp_valid_ff <= 1'b1;
            if (run_done) begin
               name_length_ff    <= '0;
               too_long_ff       <= 1'b0;
               short_checksum_ff <= '0;
               short_count_ff    <= '0;
               entry_cnt_ff      <= '0;
               slot_mod_ff       <= '0;
               err_ff            <= 1'b0;
            end else begin
               base_ff  <= base_ff - LEN_W'(CHARS_PER_ENTRY);
               addr_ff  <= base_ff - LEN_W'(CHARS_PER_ENTRY);
               slot_ff  <= '0;
               order_ff <= order_ff - ORD_W'(1);
               first_ff <= 1'b0;
            end
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // capture read data in the cycle after the read
   always_ff @(posedge clock) begin
      cap_slot_ff <= slot_ff;
      cap_cls_ff  <= cls_in;
      if (cap_valid_ff) begin
         char_ff[cap_slot_ff] <= char_in;
      end
   end

   always_comb begin
      case (cap_cls_ff)
         CLS_STORED: char_in = {8'h00, rd_data_ff};
         CLS_TERM:   char_in = CHAR_TERM;
         CLS_PAD:    char_in = CHAR_PAD;
         default:    char_in = CHAR_PAD;
      endcase
   end

   // entry header and layout
   assign hdr.order    = {{(8 - ORD_W){1'b0}}, order_ff} | (first_ff ? ORDER_LAST_FLAG : 8'h00);
   assign hdr.checksum = short_checksum_ff;
   assign hdr.err      = err_ff;

   lneb_pack u_pack (
      .hdr   (hdr),
      .chars (char_ff),
      .word0 (word0),
      .word1 (word1),
      .word2 (word2),
      .word3 (word3)
   );

   // result payload register
   always_ff @(posedge clock) begin
      if (emit_load) begin
         word0_ff  <= word0;
         word1_ff  <= word1;
         word2_ff  <= word2;
         word3_ff  <= word3;
         last_ff   <= run_done;
         status_ff <= err_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_entry_word0 = word0_ff;
   assign rsp_entry_word1 = word1_ff;
   assign rsp_entry_word2 = word2_ff;
   assign rsp_entry_word3 = word3_ff;
   assign rsp_last_entry  = last_ff;
   assign rsp_status      = status_ff;

`ifndef SYNTH
   // length never exceeds the store
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      name_length_ff <= LEN_W'(NAME_MAX))
      else $error("name length past store depth");

   // entry count tracks an empty name
   a_cnt_empty: assert property (@(posedge clock) disable iff (reset)
      (name_length_ff == '0) == (entry_cnt_ff == '0))
      else $error("entry count out of step with name length");

   // the slot counter wraps within an entry
   a_slot_mod: assert property (@(posedge clock) disable iff (reset)
      slot_mod_ff < SLOT_W'(CHARS_PER_ENTRY))
      else $error("slot count past entry size");

   // a fetch never runs on order zero
   a_order_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH) |-> (order_ff != '0))
      else $error("fetch with no entry left");

   // a loaded entry shows up as a valid response
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      emit_load |=> rsp_valid)
      else $error("entry load lost");
`endif

endmodule

`default_nettype wire

// File: tb/lfn_entry_checker.sv
// lfn_entry_checker: watches both channels of the long-name entry builder and checks each entry
// keeps its own copy of the name store, short-name checksum and name length; needs lneb_pkg
`timescale 1ns / 1ps

module lfn_entry_checker
   import lneb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_data_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [63:0] rsp_entry_word0,
   input  logic [63:0] rsp_entry_word1,
   input  logic [63:0] rsp_entry_word2,
   input  logic [63:0] rsp_entry_word3,
   input  logic        rsp_last_entry,
   input  logic        rsp_status,
   output int          mismatch_cnt,
   output int          entries_pending
);

   typedef struct {
      logic [63:0] word0;
      logic [63:0] word1;
      logic [63:0] word2;
      logic [63:0] word3;
      logic        last_entry;
      logic        status;
   } lfn_entry_type;

   // model copy of the name being collected
   logic [7:0]  name_buf [NAME_MAX];
   int unsigned model_len;
   bit          name_over;
   logic [7:0]  short_sum;
   int unsigned short_seen;

   // entries owed by the block, oldest first
   lfn_entry_type entry_q [$];

   // one field compare
   task automatic compare_field(input string field, input logic [63:0] want,
                                input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
         mismatch_cnt++;
      end
   endtask

   always @(posedge clock) begin : predict_and_check
      int unsigned n_entries;
      int unsigned ci;
      int          k;
      int          s;
      logic [255:0] raw;
      logic [15:0]  ch;
      logic [7:0]   ord;
      lfn_entry_type ent;

      if (reset) begin
         model_len = 0;
         name_over = 1'b0;
         short_sum = 8'h00;
         short_seen = 0;
         entry_q.delete();
      end else begin
         // model update on each accepted request
         if (req_valid && !req_stall) begin
            case (req_func)
               FUNC_SHORT: begin
                  // rotate right then add, only the first eleven bytes count
                  if (short_seen < SHORT_LEN) begin
                     short_sum = {short_sum[0], short_sum[7:1]} + req_data_byte;
                     short_seen++;
                  end
               end
               FUNC_NAME: begin
                  if (model_len < NAME_MAX) begin
                     name_buf[model_len] = req_data_byte;
                     model_len++;
                  end else begin
                     name_over = 1'b1;
                  end
               end
               FUNC_END: begin
                  if (name_over) begin
                     // too long: one error result with zero words
                     ent.word0 = '0;
                     ent.word1 = '0;
                     ent.word2 = '0;
                     ent.word3 = '0;
                     ent.last_entry = 1'b1;
                     ent.status = 1'b1;
                     entry_q.push_back(ent);
                  end else begin
                     // entries go out highest order first, carrying the tail of the name
                     n_entries = (model_len + CHARS_PER_ENTRY - 1) / CHARS_PER_ENTRY;
                     for (k = 0; k < n_entries; k++) begin
                        ord = 8'(n_entries - k);
                        if (k == 0)
                           ord = ord | ORDER_LAST_FLAG;
                        raw = '0;
                        raw[7:0] = ord;
                        raw[11*8 +: 8] = ATTR_LONG_NAME;
                        raw[13*8 +: 8] = short_sum;
                        for (s = 0; s < CHARS_PER_ENTRY; s++) begin
                           ci = (n_entries - 1 - k) * CHARS_PER_ENTRY + s;
                           if (ci < model_len)
                              ch = {8'h00, name_buf[ci]};
                           else if (ci == model_len)
                              ch = CHAR_TERM;
                           else
                              ch = CHAR_PAD;
                           raw[int'(SLOT_OFFSET[s]) * 8 +: 16] = ch;
                        end
                        ent.word0 = raw[63:0];
                        ent.word1 = raw[127:64];
                        ent.word2 = raw[191:128];
                        ent.word3 = raw[255:192];
                        ent.last_entry = (k == n_entries - 1);
                        ent.status = 1'b0;
                        entry_q.push_back(ent);
                     end
                  end
                  model_len = 0;
                  name_over = 1'b0;
                  short_sum = 8'h00;
                  short_seen = 0;
               end
               default: ;
            endcase
         end

         // compare each accepted entry with the oldest one owed
         if (rsp_valid && !rsp_stall) begin
            if (entry_q.size() == 0) begin
               $display("%0t: entry with none expected: actual %h %h %h %h last %b status %b",
                        $time, rsp_entry_word0, rsp_entry_word1, rsp_entry_word2,
                        rsp_entry_word3, rsp_last_entry, rsp_status);
               mismatch_cnt++;
            end else begin
               ent = entry_q.pop_front();
               compare_field("entry_word0", ent.word0, rsp_entry_word0);
               compare_field("entry_word1", ent.word1, rsp_entry_word1);
               compare_field("entry_word2", ent.word2, rsp_entry_word2);
               compare_field("entry_word3", ent.word3, rsp_entry_word3);
               compare_field("last_entry", 64'(ent.last_entry), 64'(rsp_last_entry));
               compare_field("status", 64'(ent.status), 64'(rsp_status));
            end
         end
      end
      entries_pending <= entry_q.size();
   end

endmodule

// File: tb/tb_top.sv
// tb_top: drives requests into long_name_entry_builder and stalls its entry output at random
// the checking lives in lfn_entry_checker; needs lneb_pkg and the builder rtl
`timescale 1ns / 1ps

module tb_top;
   import lneb_pkg::*;

   localparam logic [1:0] FUNC_UNUSED  = 2'd3;
   localparam int         ITEMS        = 470;
   localparam int         IDLE_LIMIT   = 2000;
   localparam int         DRAIN_CYCLES = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func = FUNC_SHORT;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_entry_word0;
   logic [63:0] rsp_entry_word1;
   logic [63:0] rsp_entry_word2;
   logic [63:0] rsp_entry_word3;
   logic        rsp_last_entry;
   logic        rsp_status;

   int mismatch_cnt;
   int entries_pending;
   int items_sent = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int idle_cycles = 0;

   long_name_entry_builder dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_entry_word0 (rsp_entry_word0),
      .rsp_entry_word1 (rsp_entry_word1),
      .rsp_entry_word2 (rsp_entry_word2),
      .rsp_entry_word3 (rsp_entry_word3),
      .rsp_last_entry  (rsp_last_entry),
      .rsp_status      (rsp_status)
   );

   lfn_entry_checker chk (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_entry_word0 (rsp_entry_word0),
      .rsp_entry_word1 (rsp_entry_word1),
      .rsp_entry_word2 (rsp_entry_word2),
      .rsp_entry_word3 (rsp_entry_word3),
      .rsp_last_entry  (rsp_last_entry),
      .rsp_status      (rsp_status),
      .mismatch_cnt    (mismatch_cnt),
      .entries_pending (entries_pending)
   );

   // 100 MHz clock
   initial begin
      forever #5 clock = ~clock;
   end

   // random receiver stall
   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   // count cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   // watchdog
   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("Verification failed");
      $finish;
   end

   // one request, with random idle cycles ahead of it
   task automatic send_req(input logic [1:0] func, input logic [7:0] data);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_data_byte <= data;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      if (func != FUNC_UNUSED)
         items_sent++;
   endtask

   // one whole name; scrambled names move some short-name bytes behind the long name
   task automatic send_name(input int unsigned n_short, input int unsigned n_long,
                            input bit scramble);
      int unsigned early;
      early = scramble ? $urandom_range(0, n_short) : n_short;
      repeat (early)
         send_req(FUNC_SHORT, 8'($urandom));
      repeat (n_long) begin
         if ($urandom_range(0, 99) < 3)
            send_req(FUNC_UNUSED, 8'($urandom));
         send_req(FUNC_NAME, 8'($urandom));
      end
      repeat (n_short - early)
         send_req(FUNC_SHORT, 8'($urandom));
      send_req(FUNC_END, 8'($urandom));
   endtask

   // random name shape: mostly short names, some empty, some at or one below a multiple of 13
   task automatic random_name();
      int unsigned pick;
      int unsigned n_short;
      int unsigned n_long;
      pick = $urandom_range(0, 99);
      if (pick < 8)
         n_long = 0;
      else if (pick < 25)
         n_long = CHARS_PER_ENTRY * $urandom_range(1, 3) - $urandom_range(0, 1);
      else
         n_long = $urandom_range(1, 30);
      pick = $urandom_range(0, 99);
      if (pick < 70)
         n_short = SHORT_LEN;
      else if (pick < 85)
         n_short = $urandom_range(0, SHORT_LEN - 1);
      else
         n_short = $urandom_range(SHORT_LEN + 1, SHORT_LEN + 4);
      send_name(n_short, n_long, $urandom_range(0, 9) == 0);
   endtask

   initial begin : stimulus
      int phase;
      int names;
      int i;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 20;
      recv_idle_pct = 55;

      // directed: empty name, unused code, full short name plus an extra byte
      send_req(FUNC_END, 8'hFF);
      send_req(FUNC_UNUSED, 8'hA5);
      for (i = 0; i <= SHORT_LEN; i++)
         send_req(FUNC_SHORT, (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom));
      // zero character and byte extremes in the long name
      send_req(FUNC_NAME, 8'h00);
      send_req(FUNC_NAME, 8'hFF);
      send_req(FUNC_NAME, 8'h80);
      send_req(FUNC_NAME, 8'h7F);
      send_req(FUNC_END, 8'h00);
      // incomplete short name
      send_req(FUNC_SHORT, 8'h01);
      send_req(FUNC_SHORT, 8'hFE);
      send_req(FUNC_NAME, 8'h41);
      send_req(FUNC_END, 8'h55);

      // random names in three idle patterns
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 20;
               recv_idle_pct = 55;
            end
            1: begin
               send_idle_pct = 55;
               recv_idle_pct = 20;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         // longest legal name, then one byte past the limit
         if (phase == 0)
            send_name(0, NAME_MAX, 1'b0);
         else if (phase == 1)
            send_name(0, NAME_MAX + 1, 1'b0);
         names = 0;
         while (items_sent < (phase + 1) * ITEMS / 3 || names < 1) begin
            random_name();
            names++;
         end
      end

      // drain
      req_valid <= 1'b0;
      @(posedge clock);
      wait (entries_pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_cnt == 0 && entries_pending == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
